### sv/assert_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define PTT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: label");
// Checks that a trigger implies a consequence at the same clock edge.
`define PTT_ASSERT_IMPL(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: label");
`else
`define PTT_ASSERT_ALWAYS(label, clk, rst, cond)
`define PTT_ASSERT_IMPL(label, clk, rst, trig, cons)
`endif
`endif

### sv/ptt_pkg.sv
`timescale 1ns / 1ps
package ptt_pkg;

  // Q30 fixed point value with headroom for sums up to just under eight in magnitude.
  typedef logic signed [33:0] q_t;
  typedef logic signed [15:0] out_t;

  // Stokes parameter codes.
  typedef enum logic [1:0] {
    FUNC_I = 2'd0,
    FUNC_Q = 2'd1,
    FUNC_U = 2'd2,
    FUNC_V = 2'd3
  } func_t;

  // One request after the front end has turned its angles into phases.
  typedef struct packed {
    func_t       func;
    logic [31:0] th_phase;
    logic [31:0] ch_phase;
    logic [31:0] ch2_phase;
    logic [31:0] gm2_phase;
  } item_t;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY      = CORDIC_LAT + 6;

  localparam q_t Q_ONE    = 34'sd1073741824;
  localparam q_t GAIN_INV = 34'sd652032874;
  localparam q_t C_K1     = 34'sd379625062;
  localparam q_t C_K3     = 34'sd1138875187;
  localparam q_t C_K2     = 34'sd929887697;
  localparam q_t C_K2H    = 34'sd464943848;
  localparam q_t C_KS     = 34'sd1315059792;
  localparam out_t T00_ONE = 16'sd16384;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic q_t atan_turn(input logic [4:0] idx);
    q_t r;
    case (idx)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051E;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      5'd24: r = 34'sh00000029;
      5'd25: r = 34'sh00000014;
      5'd26: r = 34'sh0000000A;
      5'd27: r = 34'sh00000005;
      5'd28: r = 34'sh00000003;
      5'd29: r = 34'sh00000001;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // Q30 product, rounded to nearest with ties toward plus infinity.
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  // Q30 to Q2.14, rounded and saturated.
  function automatic out_t to_out(input q_t v);
    q_t t;
    logic signed [17:0] r;
    t = v + 34'sd32768;
    r = t[33:16];
    if (r > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -18'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

endpackage

### sv/ptt_front.sv
`timescale 1ns / 1ps
module ptt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          func,
  input  logic [15:0]         polar_angle,
  input  logic [15:0]         azimuth_angle,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                push_ready,
  output logic                push_valid,
  output ptt_pkg::item_t      push_item
);

  logic [15:0] reference_angle;

  // The reference angle register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_angle <= '0;
    end else if (cfg_wr_en) begin
      reference_angle <= cfg_wr_data;
    end
  end

  // Hold one classified request until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (accept) begin
      push_valid <= 1'b1;
    end else if (push_ready) begin
      push_valid <= 1'b0;
    end
  end

  // Angles become 32-bit phases; doubled angles wrap modulo one turn.
  always_ff @(posedge clk) begin
    if (accept) begin
      push_item.func      <= ptt_pkg::func_t'(func);
      push_item.th_phase  <= {polar_angle, 16'd0};
      push_item.ch_phase  <= {azimuth_angle, 16'd0};
      push_item.ch2_phase <= {azimuth_angle[14:0], 17'd0};
      push_item.gm2_phase <= {reference_angle[14:0], 17'd0};
    end
  end

endmodule

### sv/ptt_fifo.sv
`timescale 1ns / 1ps
module ptt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ptt_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output ptt_pkg::item_t rd_item
);

  ptt_pkg::item_t mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rd_ptr];

  // Two-entry queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

### sv/ptt_cordic.sv
`timescale 1ns / 1ps
module ptt_cordic (
  input  logic         clk,
  input  logic [31:0]  phase,
  output ptt_pkg::q_t  sin_val,
  output ptt_pkg::q_t  cos_val
);

  localparam int N = ptt_pkg::CORDIC_STEPS;

  logic [31:0] ph_quarter;
  logic [31:0] ph_rot;
  logic        flip_in;

  ptt_pkg::q_t xs [0:N];
  ptt_pkg::q_t ys [0:N];
  ptt_pkg::q_t zs [0:N];
  logic        flips [0:N];

  // Fold the phase into the half turn around zero.
  assign ph_quarter = phase + 32'h4000_0000;
  assign flip_in    = ph_quarter[31];
  assign ph_rot     = flip_in ? (phase + 32'h8000_0000) : phase;

  always_ff @(posedge clk) begin
    xs[0]    <= ptt_pkg::GAIN_INV;
    ys[0]    <= '0;
    zs[0]    <= {{2{ph_rot[31]}}, ph_rot};
    flips[0] <= flip_in;
  end

  // One rotation step per pipeline stage.
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      flips[i+1] <= flips[i];
      if (!zs[i][33]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ptt_pkg::atan_turn(5'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ptt_pkg::atan_turn(5'(i));
      end
    end
  end

  // Undo the fold.
  always_ff @(posedge clk) begin
    sin_val <= flips[N] ? -ys[N] : ys[N];
    cos_val <= flips[N] ? -xs[N] : xs[N];
  end

endmodule

### sv/ptt_back.sv
`timescale 1ns / 1ps
module ptt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ptt_pkg::item_t in_item,
  output logic           done,
  output logic [15:0]    t00_real,
  output logic [15:0]    t10_real,
  output logic [15:0]    t11_real,
  output logic [15:0]    t11_imag,
  output logic [15:0]    t20_real,
  output logic [15:0]    t21_real,
  output logic [15:0]    t21_imag,
  output logic [15:0]    t22_real,
  output logic [15:0]    t22_imag
);

  localparam int L = ptt_pkg::CORDIC_LAT;

  ptt_pkg::q_t st, ct, s1, c1, s2, c2, sg, cg;
  logic            vd [0:L-1];
  ptt_pkg::func_t  fd [0:L-1];

  ptt_cordic u_cth (.clk(clk), .phase(in_item.th_phase),  .sin_val(st), .cos_val(ct));
  ptt_cordic u_cch (.clk(clk), .phase(in_item.ch_phase),  .sin_val(s1), .cos_val(c1));
  ptt_cordic u_cc2 (.clk(clk), .phase(in_item.ch2_phase), .sin_val(s2), .cos_val(c2));
  ptt_cordic u_cgm (.clk(clk), .phase(in_item.gm2_phase), .sin_val(sg), .cos_val(cg));

  // Valid and Stokes code travel beside the rotators.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        vd[k] <= 1'b0;
      end
    end else begin
      vd[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    fd[0] <= in_item.func;
    for (int k = 1; k < L; k++) begin
      fd[k] <= fd[k-1];
    end
  end

  // Stage 1: squares and first products.
  ptt_pkg::q_t    u_sel, w_sel;
  ptt_pkg::q_t    ct2, st2, stct, a_qu, pp, rr0, vt10_1;
  ptt_pkg::q_t    c1_1, s1_1, c2_1, s2_1, u_1, w_1;
  ptt_pkg::func_t fn1;
  logic           vl1;

  assign u_sel = (fd[L-1] == ptt_pkg::FUNC_Q) ? cg : sg;
  assign w_sel = (fd[L-1] == ptt_pkg::FUNC_Q) ? sg : cg;

  always_ff @(posedge clk) begin
    ct2    <= ptt_pkg::qmul(ct, ct);
    st2    <= ptt_pkg::qmul(st, st);
    stct   <= ptt_pkg::qmul(st, ct);
    a_qu   <= ptt_pkg::qmul(ptt_pkg::C_K2, st);
    pp     <= ptt_pkg::qmul(u_sel, ct);
    rr0    <= ptt_pkg::qmul(w_sel, ct);
    vt10_1 <= ptt_pkg::qmul(ptt_pkg::C_KS, ct);
    c1_1   <= c1;
    s1_1   <= s1;
    c2_1   <= c2;
    s2_1   <= s2;
    u_1    <= u_sel;
    w_1    <= w_sel;
    fn1    <= fd[L-1];
  end

  // Stage 2: second-level products.
  ptt_pkg::q_t    e4i, ai, bi, g2, qq, m1, m2, m3, m4, r2, vv2_2, vv3_2, vt10_2;
  ptt_pkg::q_t    a_qu2, c1_2, s1_2, c2_2, s2_2;
  ptt_pkg::func_t fn2;
  logic           vl2;

  always_ff @(posedge clk) begin
    e4i    <= ptt_pkg::qmul(ptt_pkg::C_K1, 34'sd3 * ct2 - ptt_pkg::Q_ONE);
    ai     <= ptt_pkg::qmul(ptt_pkg::C_K2, stct);
    bi     <= ptt_pkg::qmul(ptt_pkg::C_K2H, st2);
    g2     <= ptt_pkg::qmul(u_1, st2);
    qq     <= ptt_pkg::qmul(u_1, ptt_pkg::Q_ONE + ct2);
    m1     <= ptt_pkg::qmul(pp, c1_1);
    m2     <= ptt_pkg::qmul(w_1, s1_1);
    m3     <= ptt_pkg::qmul(pp, s1_1);
    m4     <= ptt_pkg::qmul(w_1, c1_1);
    r2     <= rr0 <<< 1;
    vv2_2  <= -ptt_pkg::qmul(a_qu, c1_1);
    vv3_2  <= -ptt_pkg::qmul(a_qu, s1_1);
    vt10_2 <= vt10_1;
    a_qu2  <= a_qu;
    c1_2   <= c1_1;
    s1_2   <= s1_1;
    c2_2   <= c2_1;
    s2_2   <= s2_1;
    fn2    <= fn1;
  end

  // Stage 3: first-rank terms and second-rank partial products.
  ptt_pkg::q_t    re1, im1;
  ptt_pkg::q_t    vi5, vi6, vi7, vi8, h3, p5, p6, n1, n2, n3, n4;
  ptt_pkg::q_t    e4i_3, vv2_3, vv3_3, vt10_3;
  ptt_pkg::func_t fn3;
  logic           vl3;

  assign re1 = (fn2 == ptt_pkg::FUNC_Q) ? (m1 - m2) : (m1 + m2);
  assign im1 = (fn2 == ptt_pkg::FUNC_Q) ? (m3 + m4) : (m3 - m4);

  always_ff @(posedge clk) begin
    vi5    <= -ptt_pkg::qmul(ai, c1_2);
    vi6    <= -ptt_pkg::qmul(ai, s1_2);
    vi7    <= ptt_pkg::qmul(bi, c2_2);
    vi8    <= ptt_pkg::qmul(bi, s2_2);
    h3     <= ptt_pkg::qmul(ptt_pkg::C_K3, g2);
    p5     <= ptt_pkg::qmul(a_qu2, re1);
    p6     <= ptt_pkg::qmul(a_qu2, im1);
    n1     <= ptt_pkg::qmul(qq, c2_2);
    n2     <= ptt_pkg::qmul(r2, s2_2);
    n3     <= ptt_pkg::qmul(qq, s2_2);
    n4     <= ptt_pkg::qmul(r2, c2_2);
    e4i_3  <= e4i;
    vv2_3  <= vv2_2;
    vv3_3  <= vv3_2;
    vt10_3 <= vt10_2;
    fn3    <= fn2;
  end

  // Stage 4: second-rank terms.
  ptt_pkg::q_t    re2, im2;
  ptt_pkg::q_t    p7, p8, vi5_4, vi6_4, vi7_4, vi8_4, h4, p5_4, p6_4;
  ptt_pkg::q_t    e4i_4, vv2_4, vv3_4, vt10_4;
  ptt_pkg::func_t fn4;
  logic           vl4;

  assign re2 = (fn3 == ptt_pkg::FUNC_Q) ? (n1 - n2) : (n1 + n2);
  assign im2 = (fn3 == ptt_pkg::FUNC_Q) ? (n3 + n4) : (n3 - n4);

  always_ff @(posedge clk) begin
    p7     <= ptt_pkg::qmul(ptt_pkg::C_K2H, re2);
    p8     <= ptt_pkg::qmul(ptt_pkg::C_K2H, im2);
    vi5_4  <= vi5;
    vi6_4  <= vi6;
    vi7_4  <= vi7;
    vi8_4  <= vi8;
    h4     <= h3;
    p5_4   <= p5;
    p6_4   <= p6;
    e4i_4  <= e4i_3;
    vv2_4  <= vv2_3;
    vv3_4  <= vv3_3;
    vt10_4 <= vt10_3;
    fn4    <= fn3;
  end

  // Valid flags of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vl1  <= 1'b0;
      vl2  <= 1'b0;
      vl3  <= 1'b0;
      vl4  <= 1'b0;
      done <= 1'b0;
    end else begin
      vl1  <= vd[L-1];
      vl2  <= vl1;
      vl3  <= vl2;
      vl4  <= vl3;
      done <= vl4;
    end
  end

  // Pick the components of this Stokes parameter; the rest are zero.
  ptt_pkg::q_t v [0:8];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      v[k] = '0;
    end
    unique case (fn4)
      ptt_pkg::FUNC_I: begin
        v[0] = ptt_pkg::Q_ONE;
        v[4] = e4i_4;
        v[5] = vi5_4;
        v[6] = vi6_4;
        v[7] = vi7_4;
        v[8] = vi8_4;
      end
      ptt_pkg::FUNC_Q: begin
        v[4] = -h4;
        v[5] = -p5_4;
        v[6] = -p6_4;
        v[7] = -p7;
        v[8] = -p8;
      end
      ptt_pkg::FUNC_U: begin
        v[4] = h4;
        v[5] = p5_4;
        v[6] = p6_4;
        v[7] = p7;
        v[8] = p8;
      end
      ptt_pkg::FUNC_V: begin
        v[1] = vt10_4;
        v[2] = vv2_4;
        v[3] = vv3_4;
      end
      default: begin
        v[0] = '0;
      end
    endcase
  end

  // Output register, one result per strobe.
  always_ff @(posedge clk) begin
    t00_real <= ptt_pkg::to_out(v[0]);
    t10_real <= ptt_pkg::to_out(v[1]);
    t11_real <= ptt_pkg::to_out(v[2]);
    t11_imag <= ptt_pkg::to_out(v[3]);
    t20_real <= ptt_pkg::to_out(v[4]);
    t21_real <= ptt_pkg::to_out(v[5]);
    t21_imag <= ptt_pkg::to_out(v[6]);
    t22_real <= ptt_pkg::to_out(v[7]);
    t22_imag <= ptt_pkg::to_out(v[8]);
  end

endmodule

### sv/polarization_tensor_tkq.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy stays low since the pipeline never stalls.
// A request runs from the front register through the queue into four rotator pipelines,
// each of 30 steps, and then through four multiply stages and an output register.
// Reset (rst, synchronous, active high) clears all valid flags and the reference angle.
module polarization_tensor_tkq (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] polar_angle,
  input  logic [15:0] azimuth_angle,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        done,
  output logic [15:0] t00_real,
  output logic [15:0] t10_real,
  output logic [15:0] t11_real,
  output logic [15:0] t11_imag,
  output logic [15:0] t20_real,
  output logic [15:0] t21_real,
  output logic [15:0] t21_imag,
  output logic [15:0] t22_real,
  output logic [15:0] t22_imag
);

  `include "assert_macros.svh"

  logic           accept;
  logic           push_valid;
  logic           fifo_full;
  logic           pop_valid;
  ptt_pkg::item_t push_item;
  ptt_pkg::item_t pop_item;

  // The front end waits only when the queue is full.
  assign busy   = push_valid & fifo_full;
  assign accept = start & ~busy;

  ptt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .func          (func),
    .polar_angle   (polar_angle),
    .azimuth_angle (azimuth_angle),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .push_ready    (~fifo_full),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  ptt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push_valid & ~fifo_full),
    .wr_item  (push_item),
    .full     (fifo_full),
    .rd_en    (pop_valid),
    .rd_valid (pop_valid),
    .rd_item  (pop_item)
  );

  ptt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_item  (pop_item),
    .done     (done),
    .t00_real (t00_real),
    .t10_real (t10_real),
    .t11_real (t11_real),
    .t11_imag (t11_imag),
    .t20_real (t20_real),
    .t21_real (t21_real),
    .t21_imag (t21_imag),
    .t22_real (t22_real),
    .t22_imag (t22_imag)
  );

  // The back end drains every cycle, so the queue never fills.
  `PTT_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  // Every strobe belongs to a request accepted a fixed time before.
  `PTT_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(accept, ptt_pkg::LATENCY + 1))
  // Only the intensity gives a monopole, and then the first rank is empty.
  `PTT_ASSERT_IMPL(a_t00_only_i, clk, rst, done && t00_real != 16'd0,
    t00_real == ptt_pkg::T00_ONE && t10_real == 16'd0 && t11_real == 16'd0)

endmodule

### bench/polarization_tensor_tkq_tb.sv
`timescale 1ns / 1ps
module polarization_tensor_tkq_tb;

  // Nine components packed in port order: t00 t10 t11r t11i t20 t21r t21i t22r t22i.
  typedef logic [8:0][15:0] tensor_t;

  // One row of the directed table.
  typedef struct {
    ptt_pkg::func_t f;
    logic [15:0]    theta;
    logic [15:0]    chi;
    bit             typed;
    logic [15:0]    t00;
  } row_t;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint K1 = 379625062;
  localparam longint K3 = 1138875187;
  localparam longint K2 = 929887697;
  localparam longint K2H = 464943848;
  localparam longint KS = 1315059792;
  localparam longint INV_GAIN = 652032874;
  localparam longint ARCTAN [30] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
    'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
    'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = '0;
  logic [15:0] polar_angle = '0;
  logic [15:0] azimuth_angle = '0;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic done;
  tensor_t got;

  tensor_t tensor_q[$];
  logic [15:0] gamma_reg = '0;
  int mismatches = 0;
  int requests = 0;
  int results = 0;
  int gammas = 0;
  bit idle_off = 1'b0;

  polarization_tensor_tkq dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .polar_angle(polar_angle), .azimuth_angle(azimuth_angle),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .done(done),
    .t00_real(got[8]), .t10_real(got[7]), .t11_real(got[6]), .t11_imag(got[5]),
    .t20_real(got[4]), .t21_real(got[3]), .t21_imag(got[2]),
    .t22_real(got[1]), .t22_imag(got[0])
  );

  always #5 clk = ~clk;

  // Product of two Q30 values, rounded half up.
  function automatic longint mulq(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // Rotation-mode CORDIC on a 32-bit phase; quadrants 2 and 3 are folded by a half turn.
  function automatic void sincos(logic [31:0] ph, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    flip = ph[31] ^ ph[30];
    if (flip) begin
      ph = ph + 32'h80000000;
    end
    z = longint'($signed(ph));
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  // Q30 to Q2.14 with rounding and saturation.
  function automatic logic [15:0] q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Tensor components for one Stokes index and direction under the current gamma.
  function automatic tensor_t tensor_of(ptt_pkg::func_t f, logic [15:0] th, logic [15:0] ch);
    longint v [9];
    longint st, ct, s1, c1, s2, c2, sg, cg, ct2, st2, stct, opc, a, p, q, r, re, im;
    logic [31:0] chp;
    tensor_t t;
    chp = {ch, 16'h0};
    sincos({th, 16'h0}, st, ct);
    sincos(chp, s1, c1);
    sincos(chp << 1, s2, c2);
    sincos({gamma_reg, 16'h0} << 1, sg, cg);
    ct2 = mulq(ct, ct);
    st2 = mulq(st, st);
    stct = mulq(st, ct);
    opc = ONE_Q30 + ct2;
    foreach (v[j]) v[j] = 0;
    case (f)
      ptt_pkg::FUNC_I: begin
        v[0] = ONE_Q30;
        v[4] = mulq(K1, 3 * ct2 - ONE_Q30);
        a = mulq(K2, stct);
        v[5] = -mulq(a, c1);
        v[6] = -mulq(a, s1);
        a = mulq(K2H, st2);
        v[7] = mulq(a, c2);
        v[8] = mulq(a, s2);
      end
      ptt_pkg::FUNC_Q: begin
        v[4] = -mulq(K3, mulq(cg, st2));
        p = mulq(cg, ct);
        re = mulq(p, c1) - mulq(sg, s1);
        im = mulq(p, s1) + mulq(sg, c1);
        a = mulq(K2, st);
        v[5] = -mulq(a, re);
        v[6] = -mulq(a, im);
        q = mulq(cg, opc);
        r = 2 * mulq(sg, ct);
        re = mulq(q, c2) - mulq(r, s2);
        im = mulq(q, s2) + mulq(r, c2);
        v[7] = -mulq(K2H, re);
        v[8] = -mulq(K2H, im);
      end
      ptt_pkg::FUNC_U: begin
        v[4] = mulq(K3, mulq(sg, st2));
        p = mulq(sg, ct);
        re = mulq(p, c1) + mulq(cg, s1);
        im = mulq(p, s1) - mulq(cg, c1);
        a = mulq(K2, st);
        v[5] = mulq(a, re);
        v[6] = mulq(a, im);
        q = mulq(sg, opc);
        r = 2 * mulq(cg, ct);
        re = mulq(q, c2) + mulq(r, s2);
        im = mulq(q, s2) - mulq(r, c2);
        v[7] = mulq(K2H, re);
        v[8] = mulq(K2H, im);
      end
      default: begin
        v[1] = mulq(KS, ct);
        a = mulq(K2, st);
        v[2] = -mulq(a, c1);
        v[3] = -mulq(a, s1);
      end
    endcase
    for (int j = 0; j < 9; j++) t[8 - j] = q14(v[j]);
    return t;
  endfunction

  // Offer one request, idling at random, and queue its tensor once accepted.
  task automatic send(ptt_pkg::func_t f, logic [15:0] th, logic [15:0] ch, bit typed,
                      logic [15:0] t00);
    tensor_t t;
    forever begin
      @(negedge clk);
      if (!idle_off && $urandom_range(99) < 29) begin
        start = 1'b0;
      end else begin
        func = f;
        polar_angle = th;
        azimuth_angle = ch;
        start = 1'b1;
        @(posedge clk);
        if (!busy) break;
      end
    end
    t = tensor_of(f, th, ch);
    if (typed) begin
      // Values read straight off the formulas: T00 is one for I, zero otherwise.
      t[8] = t00;
      if (f != ptt_pkg::FUNC_V) begin
        t[7] = '0; t[6] = '0; t[5] = '0;
      end
    end
    tensor_q = {tensor_q, t};
    requests++;
  endtask

  // Let the pipeline drain completely.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (tensor_q.size() == 0);
    repeat (ptt_pkg::LATENCY + 4) @(negedge clk);
  endtask

  // Write gamma while the block is idle.
  task automatic set_gamma(logic [15:0] g);
    drain();
    cfg_wr_data = g;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    gamma_reg = g;
    gammas++;
  endtask

  // Compare every strobed result against the oldest queued tensor.
  always @(posedge clk) begin
    tensor_t e;
    if (!rst && done) begin
      results++;
      if (tensor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        e = tensor_q.pop_front();
        for (int k = 8; k >= 0; k--) begin
          if (got[k] !== e[k]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("component %0d: expected %h, got %h", 8 - k, e[k], got[k]);
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    ptt_pkg::func_t fr;
    rows = '{
      '{ptt_pkg::FUNC_I, 16'h0000, 16'h0000, 1, 16'h4000},
      '{ptt_pkg::FUNC_Q, 16'h0000, 16'h0000, 1, 16'h0000},
      '{ptt_pkg::FUNC_U, 16'h0000, 16'h0000, 1, 16'h0000},
      '{ptt_pkg::FUNC_V, 16'h0000, 16'h0000, 1, 16'h0000},
      '{ptt_pkg::FUNC_I, 16'hFFFF, 16'hFFFF, 1, 16'h4000},
      '{ptt_pkg::FUNC_Q, 16'hFFFF, 16'hFFFF, 1, 16'h0000},
      '{ptt_pkg::FUNC_U, 16'hFFFF, 16'hFFFF, 1, 16'h0000},
      '{ptt_pkg::FUNC_V, 16'hFFFF, 16'hFFFF, 1, 16'h0000},
      '{ptt_pkg::FUNC_I, 16'h4000, 16'h4000, 0, 16'h0},
      '{ptt_pkg::FUNC_Q, 16'h4000, 16'h8000, 0, 16'h0},
      '{ptt_pkg::FUNC_U, 16'h8000, 16'hC000, 0, 16'h0},
      '{ptt_pkg::FUNC_V, 16'hC000, 16'h2000, 0, 16'h0},
      '{ptt_pkg::FUNC_I, 16'h2000, 16'h6000, 0, 16'h0},
      '{ptt_pkg::FUNC_Q, 16'h3FFF, 16'h7FFF, 0, 16'h0},
      '{ptt_pkg::FUNC_U, 16'hBFFF, 16'h4001, 0, 16'h0},
      '{ptt_pkg::FUNC_V, 16'h8000, 16'hA000, 0, 16'h0},
      '{ptt_pkg::FUNC_V, 16'h4000, 16'hE000, 0, 16'h0},
      '{ptt_pkg::FUNC_I, 16'h1555, 16'h5555, 0, 16'h0},
      '{ptt_pkg::FUNC_Q, 16'h0001, 16'hAAAA, 0, 16'h0},
      '{ptt_pkg::FUNC_U, 16'h7FFF, 16'h0001, 0, 16'h0}};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows, first at the reset gamma and then at gamma FFFF and gamma 2000.
    foreach (rows[i]) send(rows[i].f, rows[i].theta, rows[i].chi, rows[i].typed, rows[i].t00);
    set_gamma(16'hFFFF);
    foreach (rows[i]) send(rows[i].f, rows[i].theta, rows[i].chi, 0, 16'h0);
    set_gamma(16'h2000);
    foreach (rows[i]) send(rows[i].f, rows[i].theta, rows[i].chi, 0, 16'h0);

    // Random requests in phases, each after its own gamma write; phase 3 sends without idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gamma(16'h0000);
        1: set_gamma(16'h8000);
        2: set_gamma(16'h4000);
        default: set_gamma(16'($urandom));
      endcase
      idle_off = (ph == 3);
      for (int n = 0; n < 230; n++) begin
        fr = ptt_pkg::func_t'($urandom_range(3));
        send(fr, 16'($urandom), 16'($urandom), 0, 16'h0);
        if (n == 100) drain();
      end
    end
    drain();

    $display("Covered %0d requests, %0d results, %0d gamma settings.",
             requests, results, gammas);
    if (mismatches == 0 && tensor_q.size() == 0) begin
      $display("PASS polarization_tensor_tkq");
    end else begin
      $display("FAIL polarization_tensor_tkq");
    end
    $finish;
  end

  // Watchdog against a hung pipeline.
  initial begin
    #10_000_000;
    $display("FAIL polarization_tensor_tkq");
    $finish;
  end

endmodule

### polarization_tensor_tkq.f
+incdir+sv
sv/ptt_pkg.sv
sv/ptt_front.sv
sv/ptt_fifo.sv
sv/ptt_cordic.sv
sv/ptt_back.sv
sv/polarization_tensor_tkq.sv
bench/polarization_tensor_tkq_tb.sv
